@@ design/ced_pkg.sv @@
`timescale 1ns / 1ps

package ced_pkg;

  // Most bytes that one input byte can release.
  localparam int unsigned MAX_RESULTS = 4;
  localparam int unsigned CNT_W = 3;
  localparam int unsigned IDX_W = 2;

  // Character codes used by the decoder.
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_3      = 8'h33;
  localparam logic [7:0] CH_7      = 8'h37;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF_HI  = 8'h66;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CODE_LF   = 8'h0A;
  localparam logic [7:0] CODE_CR   = 8'h0D;
  localparam logic [7:0] CODE_TAB  = 8'h09;

  // One group of decoded bytes produced by a single input byte.
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] data;
    logic [CNT_W-1:0]            count;
    logic                        last;
  } packet_t;

  function automatic logic is_oct(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_7);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_LA) && (c <= CH_LF_HI)) ||
           ((c >= CH_UA) && (c <= CH_UF));
  endfunction

  // Value of a hex digit; meaningless for a character that is not one.
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    if (c <= CH_9) begin
      d = c;
    end else if (c >= CH_LA) begin
      d = c - 8'h57;
    end else begin
      d = c - 8'h37;
    end
    return d[3:0];
  endfunction

endpackage

@@ design/ced_front.sv @@
`timescale 1ns / 1ps

module ced_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       in_byte,
  input  logic             in_last,
  output logic             q_push,
  output ced_pkg::packet_t q_data
);
  import ced_pkg::*;

  typedef enum logic [2:0] {
    PH_NORMAL = 3'd0,
    PH_ESC    = 3'd1,
    PH_OCT1   = 3'd2,
    PH_OCT2   = 3'd3,
    PH_HEX0   = 3'd4,
    PH_HEX1   = 3'd5
  } phase_t;

  phase_t     phase;
  phase_t     phase_next;
  phase_t     plain_phase;
  logic [7:0] held_first;
  logic [7:0] held_second;
  logic [7:0] held_first_next;
  logic [7:0] held_second_next;
  logic       plain_emit;
  packet_t    pkt;

  // A backslash that is not the final byte opens an escape; anything else passes.
  always_comb begin
    plain_emit  = !((in_byte == CH_BSLASH) && !in_last);
    plain_phase = plain_emit ? PH_NORMAL : PH_ESC;
  end

  // Classify the byte against the escape phase and build its output group.
  always_comb begin
    phase_next       = PH_NORMAL;
    held_first_next  = held_first;
    held_second_next = held_second;
    pkt              = '0;
    unique case (phase)
      PH_ESC: begin
        if (in_byte == CH_N) begin
          pkt.data[0] = CODE_LF;
          pkt.count   = CNT_W'(1);
        end else if (in_byte == CH_R) begin
          pkt.data[0] = CODE_CR;
          pkt.count   = CNT_W'(1);
        end else if (in_byte == CH_T) begin
          pkt.data[0] = CODE_TAB;
          pkt.count   = CNT_W'(1);
        end else if ((in_byte == CH_X) && !in_last) begin
          phase_next = PH_HEX0;
        end else if ((in_byte >= CH_0) && (in_byte <= CH_3) && !in_last) begin
          held_first_next = in_byte;
          phase_next      = PH_OCT1;
        end else begin
          pkt.data[0] = CH_BSLASH;
          pkt.data[1] = in_byte;
          pkt.count   = CNT_W'(2);
        end
      end
      PH_OCT1: begin
        if (is_oct(in_byte) && !in_last) begin
          held_second_next = in_byte;
          phase_next       = PH_OCT2;
        end else begin
          pkt.data[0] = CH_BSLASH;
          pkt.data[1] = held_first;
          pkt.data[2] = in_byte;
          pkt.count   = CNT_W'(2) + CNT_W'(plain_emit);
          phase_next  = plain_phase;
        end
      end
      PH_OCT2: begin
        if (is_oct(in_byte)) begin
          pkt.data[0] = {held_first[1:0], held_second[2:0], in_byte[2:0]};
          pkt.count   = CNT_W'(1);
        end else begin
          pkt.data[0] = CH_BSLASH;
          pkt.data[1] = held_first;
          pkt.data[2] = held_second;
          pkt.data[3] = in_byte;
          pkt.count   = CNT_W'(3) + CNT_W'(plain_emit);
          phase_next  = plain_phase;
        end
      end
      PH_HEX0: begin
        if (is_hex(in_byte) && !in_last) begin
          held_first_next = in_byte;
          phase_next      = PH_HEX1;
        end else begin
          pkt.data[0] = CH_BSLASH;
          pkt.data[1] = CH_X;
          pkt.data[2] = in_byte;
          pkt.count   = CNT_W'(2) + CNT_W'(plain_emit);
          phase_next  = plain_phase;
        end
      end
      PH_HEX1: begin
        if (is_hex(in_byte)) begin
          pkt.data[0] = {hex_val(held_first), hex_val(in_byte)};
          pkt.count   = CNT_W'(1);
        end else begin
          pkt.data[0] = CH_BSLASH;
          pkt.data[1] = CH_X;
          pkt.data[2] = held_first;
          pkt.data[3] = in_byte;
          pkt.count   = CNT_W'(3) + CNT_W'(plain_emit);
          phase_next  = plain_phase;
        end
      end
      default: begin
        pkt.data[0] = in_byte;
        pkt.count   = CNT_W'(plain_emit);
        phase_next  = plain_phase;
      end
    endcase
    // The end of a string always closes any escape in progress.
    if (in_last) begin
      phase_next = PH_NORMAL;
    end
    pkt.last = in_last;
  end

  assign q_push = accept && (pkt.count != '0);
  assign q_data = pkt;

  // Escape phase and held digits.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_NORMAL;
      held_first  <= '0;
      held_second <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      held_first  <= held_first_next;
      held_second <= held_second_next;
    end
  end

endmodule

@@ design/ced_queue.sv @@
`timescale 1ns / 1ps

module ced_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  ced_pkg::packet_t wr_data,
  input  logic             rd_en,
  output ced_pkg::packet_t rd_data,
  output logic             q_full,
  output logic             q_empty
);
  import ced_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_QW = $clog2(DEPTH + 1);

  packet_t           slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_QW-1:0] fill;

  assign q_full  = (fill == CNT_QW'(DEPTH));
  assign q_empty = (fill == '0);
  assign rd_data = slots[rd_ptr];

  // Pointers and fill level; callers never write when full or read when empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        fill <= fill + CNT_QW'(1);
      end else if (rd_en && !wr_en) begin
        fill <= fill - CNT_QW'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

@@ design/ced_back.sv @@
`timescale 1ns / 1ps

module ced_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  ced_pkg::packet_t q_data,
  output logic             q_pop,
  input  logic             pop,
  output logic             empty,
  output logic [7:0]       out_byte,
  output logic             out_last
);
  import ced_pkg::*;

  packet_t          cur;
  logic [IDX_W-1:0] idx;
  logic             valid;
  logic             at_end;
  logic             load;

  // The group in hand is finished when its final byte is taken.
  assign at_end = (idx == IDX_W'(cur.count - CNT_W'(1)));
  assign load   = !q_empty && (!valid || (pop && at_end));
  assign q_pop  = load;

  assign empty    = !valid;
  assign out_byte = cur.data[idx];
  assign out_last = cur.last && at_end;

  // Step through the bytes of the current group, refilling from the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else if (load) begin
      valid <= 1'b1;
      idx   <= '0;
    end else if (valid && pop) begin
      if (at_end) begin
        valid <= 1'b0;
      end else begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= q_data;
    end
  end

endmodule

@@ design/c_string_escape_decoder_unit.sv @@
`timescale 1ns / 1ps
// Throughput: one raw byte per cycle in while full is low and one decoded byte per
// cycle out while pop is held and bytes wait; a byte that releases n decoded bytes
// holds the output until all are popped. The packet queue between the front and
// the output stage registers each group and absorbs such bursts.
// Reset: synchronous, active high; clears the escape phase, the queue and the output.
module c_string_escape_decoder_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte,
  output logic       out_last
);
  import ced_pkg::*;

  logic    accept;
  logic    q_push;
  logic    q_pop;
  logic    q_full;
  logic    q_empty;
  packet_t wr_pkt;
  packet_t rd_pkt;

  assign full   = q_full;
  assign accept = push && !q_full;

  // Classification and escape tracking.
  ced_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (in_byte),
    .in_last (in_last),
    .q_push  (q_push),
    .q_data  (wr_pkt)
  );

  // Packet queue between the two sides.
  ced_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (wr_pkt),
    .rd_en   (q_pop),
    .rd_data (rd_pkt),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  // Byte-at-a-time output stage.
  ced_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_data   (rd_pkt),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_byte (out_byte),
    .out_last (out_last)
  );

endmodule

@@ design/ced_checker.sv @@
`timescale 1ns / 1ps

module ced_checker (
  input logic       clk,
  input logic       rst,
  input logic       push,
  input logic       full,
  input logic       in_last,
  input logic       pop,
  input logic       empty,
  input logic [7:0] out_byte,
  input logic       out_last
);

  logic [7:0] open_strings;

  // Count strings whose final byte went in but whose final result is not out yet.
  always_ff @(posedge clk) begin
    if (rst) begin
      open_strings <= '0;
    end else begin
      open_strings <= open_strings + 8'(push && !full && in_last)
                      - 8'(pop && !empty && out_last);
    end
  end

  // Reset leaves both sides of the block idle.
  a_reset_idle: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("block not idle after reset");

  // A waiting result holds until it is taken.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(out_last)))
    else $error("waiting result changed before pop");

  // A full queue always comes with a group held in the output stage.
  a_full_has_output: assert property (@(posedge clk) disable iff (rst)
    full |-> !empty)
    else $error("queue full while output stage is empty");

  // Every string end on the output matches one taken on the input.
  a_last_matches: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && out_last) |-> (open_strings != 8'd0))
    else $error("string end delivered without a matching input");

endmodule

bind c_string_escape_decoder_unit ced_checker u_ced_checker (
  .clk      (clk),
  .rst      (rst),
  .push     (push),
  .full     (full),
  .in_last  (in_last),
  .pop      (pop),
  .empty    (empty),
  .out_byte (out_byte),
  .out_last (out_last)
);

@@ tb/ced_decode_checker.sv @@
`timescale 1ns / 1ps

// Watches both queue ports of the decoder, predicts the decoded bytes of every
// accepted raw byte and compares them with what the block releases.
module ced_decode_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       pop,
  input  logic       empty,
  input  logic [7:0] out_byte,
  input  logic       out_last,
  output int         fail_count,
  output int         outstanding,
  output int         checked_count
);
  import ced_pkg::*;

  // Where the predictor stands inside an escape sequence.
  typedef enum logic [2:0] {
    ESC_IDLE,
    ESC_START,
    ESC_OCT_ONE,
    ESC_OCT_TWO,
    ESC_HEX_ZERO,
    ESC_HEX_ONE
  } esc_state_t;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } decoded_t;

  esc_state_t esc_state;
  logic [7:0] held_a;
  logic [7:0] held_b;
  decoded_t   decoded_q[$];

  initial begin
    esc_state     = ESC_IDLE;
    held_a        = 8'h00;
    held_b        = 8'h00;
    fail_count    = 0;
    outstanding   = 0;
    checked_count = 0;
  end

  // Returns the value of a hex digit, or -1 when the character is not one.
  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
    if (c >= CH_LA && c <= CH_LF_HI) return int'(c - CH_LA) + 10;
    if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
    return -1;
  endfunction

  // Advances the escape state by one raw byte and queues the bytes it releases.
  task automatic decode_byte(input logic [7:0] c, input logic lst);
    logic [7:0] out_bytes[$];
    logic       as_plain;
    logic       c_oct;
    int         h;
    decoded_t   d;
    as_plain = 1'b0;
    c_oct    = (c >= CH_0) && (c <= CH_7);
    h        = hex_nibble(c);
    case (esc_state)
      ESC_START: begin
        esc_state = ESC_IDLE;
        if (c == CH_N) begin
          out_bytes.push_back(CODE_LF);
        end else if (c == CH_R) begin
          out_bytes.push_back(CODE_CR);
        end else if (c == CH_T) begin
          out_bytes.push_back(CODE_TAB);
        end else if (c == CH_X && !lst) begin
          esc_state = ESC_HEX_ZERO;
        end else if (c >= CH_0 && c <= CH_3 && !lst) begin
          held_a    = c;
          esc_state = ESC_OCT_ONE;
        end else begin
          out_bytes.push_back(CH_BSLASH);
          out_bytes.push_back(c);
        end
      end
      ESC_OCT_ONE: begin
        esc_state = ESC_IDLE;
        if (c_oct && !lst) begin
          held_b    = c;
          esc_state = ESC_OCT_TWO;
        end else begin
          out_bytes.push_back(CH_BSLASH);
          out_bytes.push_back(held_a);
          as_plain = 1'b1;
        end
      end
      ESC_OCT_TWO: begin
        esc_state = ESC_IDLE;
        if (c_oct) begin
          out_bytes.push_back(8'(((held_a - CH_0) << 6) | ((held_b - CH_0) << 3) |
                                 (c - CH_0)));
        end else begin
          out_bytes.push_back(CH_BSLASH);
          out_bytes.push_back(held_a);
          out_bytes.push_back(held_b);
          as_plain = 1'b1;
        end
      end
      ESC_HEX_ZERO: begin
        esc_state = ESC_IDLE;
        if (h >= 0 && !lst) begin
          held_a    = c;
          esc_state = ESC_HEX_ONE;
        end else begin
          out_bytes.push_back(CH_BSLASH);
          out_bytes.push_back(CH_X);
          as_plain = 1'b1;
        end
      end
      ESC_HEX_ONE: begin
        esc_state = ESC_IDLE;
        if (h >= 0) begin
          out_bytes.push_back(8'((hex_nibble(held_a) << 4) | h));
        end else begin
          out_bytes.push_back(CH_BSLASH);
          out_bytes.push_back(CH_X);
          out_bytes.push_back(held_a);
          as_plain = 1'b1;
        end
      end
      default: begin
        esc_state = ESC_IDLE;
        as_plain  = 1'b1;
      end
    endcase

    // A byte outside an escape: a backslash opens one unless it ends the string.
    if (as_plain) begin
      if (c == CH_BSLASH && !lst) begin
        esc_state = ESC_START;
      end else begin
        out_bytes.push_back(c);
      end
    end
    if (lst) esc_state = ESC_IDLE;

    // The last released byte of the string carries the end mark.
    for (int i = 0; i < out_bytes.size(); i++) begin
      d.value = out_bytes[i];
      d.last  = lst && (i == out_bytes.size() - 1);
      decoded_q.push_back(d);
    end
  endtask

  // Predict on each input transaction and compare each output transaction.
  always @(posedge clk) begin
    decoded_t exp_d;
    if (!rst) begin
      if (push && !full) decode_byte(in_byte, in_last);
      if (pop && !empty) begin
        checked_count++;
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected decoded byte: expected none, actual %h last %b",
                   $time, out_byte, out_last);
          fail_count++;
        end else begin
          exp_d = decoded_q.pop_front();
          if (out_byte !== exp_d.value) begin
            $display("%0t: out_byte mismatch: expected %h, actual %h",
                     $time, exp_d.value, out_byte);
            fail_count++;
          end
          if (out_last !== exp_d.last) begin
            $display("%0t: out_last mismatch: expected %b, actual %b",
                     $time, exp_d.last, out_last);
            fail_count++;
          end
        end
      end
    end
    outstanding = decoded_q.size();
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import ced_pkg::*;

  localparam int TARGET_BYTES   = 330;
  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 2000;

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  logic [7:0] in_byte;
  logic       in_last;
  logic       pop;
  logic       empty;
  logic [7:0] out_byte;
  logic       out_last;

  int fail_count;
  int outstanding;
  int checked_count;

  // Stimulus control shared with the receiver process, and the watchdog's idle count.
  logic send_gaps;
  logic pop_gaps;
  int   hold_orders;
  int   holds_done;
  int   hold_left;
  int   idle_cycles;

  int         bytes_sent;
  int         strings_sent;
  logic [7:0] body_q[$];

  c_string_escape_decoder_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .in_byte (in_byte),
    .in_last (in_last),
    .pop     (pop),
    .empty   (empty),
    .out_byte(out_byte),
    .out_last(out_last)
  );

  ced_decode_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .in_byte      (in_byte),
    .in_last      (in_last),
    .pop          (pop),
    .empty        (empty),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .fail_count   (fail_count),
    .outstanding  (outstanding),
    .checked_count(checked_count)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Receiver: pops at random or always, or holds off for a counted stretch on request.
  initial begin
    pop        = 1'b0;
    holds_done = 0;
    hold_left  = 0;
    forever begin
      @(negedge clk);
      if (rst) begin
        pop <= 1'b0;
      end else if (hold_orders != holds_done) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
        pop <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= !(pop_gaps && ($urandom_range(0, 99) < 21));
      end
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  initial idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles at %0t", WATCHDOG_LIMIT, $time);
        $display("** c_string_escape_decoder_unit: FAILED **");
        $finish;
      end
    end
  end

  // Offers one raw byte, entered and left at a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic lst);
    while (send_gaps && ($urandom_range(0, 99) < 21)) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push    <= 1'b1;
    in_byte <= b;
    in_last <= lst;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  // Sends the collected string body, marking its final byte.
  task automatic send_body();
    for (int i = 0; i < body_q.size(); i++) send_byte(body_q[i], i == body_q.size() - 1);
    body_q.delete();
    strings_sent++;
  endtask

  function automatic logic [7:0] random_hex_digit();
    int k;
    k = $urandom_range(0, 21);
    if (k < 10) return CH_0 + 8'(k);
    if (k < 16) return CH_LA + 8'(k - 10);
    return CH_UA + 8'(k - 16);
  endfunction

  // Appends one token: well-formed escapes most often, also broken ones and noise.
  task automatic add_random_token();
    int r;
    int k;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      body_q.push_back(8'($urandom_range(0, 255)));
    end else if (r < 45) begin
      k = $urandom_range(0, 2);
      body_q.push_back(CH_BSLASH);
      body_q.push_back(k == 0 ? CH_N : (k == 1 ? CH_R : CH_T));
    end else if (r < 60) begin
      body_q.push_back(CH_BSLASH);
      body_q.push_back(CH_0 + 8'($urandom_range(0, 3)));
      body_q.push_back(CH_0 + 8'($urandom_range(0, 7)));
      body_q.push_back(CH_0 + 8'($urandom_range(0, 7)));
    end else if (r < 75) begin
      body_q.push_back(CH_BSLASH);
      body_q.push_back(CH_X);
      body_q.push_back(random_hex_digit());
      body_q.push_back(random_hex_digit());
    end else if (r < 85) begin
      body_q.push_back(CH_BSLASH);
      body_q.push_back(8'($urandom_range(0, 255)));
    end else if (r < 92) begin
      body_q.push_back(CH_BSLASH);
      body_q.push_back(CH_0 + 8'($urandom_range(0, 3)));
      body_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      body_q.push_back(CH_BSLASH);
      body_q.push_back(CH_X);
      body_q.push_back($urandom_range(0, 1) ? random_hex_digit() : 8'($urandom_range(0, 255)));
      body_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_random_strings(input int upto);
    int n;
    while (bytes_sent < upto) begin
      n = $urandom_range(1, 6);
      repeat (n) add_random_token();
      send_body();
    end
  endtask

  task automatic wait_drained();
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    rst          = 1'b1;
    push         = 1'b0;
    in_byte      = 8'h00;
    in_last      = 1'b0;
    send_gaps    = 1'b1;
    pop_gaps     = 1'b1;
    hold_orders  = 0;
    bytes_sent   = 0;
    strings_sent = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed strings: byte extremes, every escape kind and the corner cases.
    body_q.push_back(8'h00); body_q.push_back(8'hFF); send_body();
    body_q.push_back(CH_BSLASH); body_q.push_back("1"); body_q.push_back("0");
    body_q.push_back("1"); send_body();
    body_q.push_back(CH_BSLASH); body_q.push_back(CH_N); body_q.push_back(CH_BSLASH);
    body_q.push_back(CH_R); body_q.push_back(CH_BSLASH); body_q.push_back(CH_T); send_body();
    body_q.push_back(CH_BSLASH); body_q.push_back(CH_X); body_q.push_back("4");
    body_q.push_back("F"); send_body();
    // Trailing lone backslash.
    body_q.push_back(CH_BSLASH); send_body();
    // String ends inside an octal escape.
    body_q.push_back(CH_BSLASH); body_q.push_back("1"); body_q.push_back("2"); send_body();
    // Failed hex escape followed by a final backslash.
    body_q.push_back(CH_BSLASH); body_q.push_back(CH_X); body_q.push_back(CH_BSLASH);
    send_body();
    // Unknown escape, then an escaped backslash at the end.
    body_q.push_back(CH_BSLASH); body_q.push_back("q"); body_q.push_back(CH_BSLASH);
    body_q.push_back(CH_BSLASH); send_body();

    // Random strings with idling on both sides.
    send_random_strings(140);

    // A long stretch with no idling at all.
    send_gaps <= 1'b0;
    pop_gaps  <= 1'b0;
    send_random_strings(210);

    // Receiver holds off while the sender keeps offering, so the block fills up.
    hold_orders <= hold_orders + 1;
    send_random_strings(250);

    // Sender pauses until every expected byte has come out.
    push <= 1'b0;
    wait_drained();

    send_gaps <= 1'b1;
    pop_gaps  <= 1'b1;
    send_random_strings(TARGET_BYTES);
    push <= 1'b0;

    wait_drained();
    repeat (10) @(negedge clk);

    $display("Summary: %0d raw bytes in %0d strings, %0d decoded bytes checked.",
             bytes_sent, strings_sent, checked_count);
    $display("Covered named, octal and hex escapes, broken escapes, stalls and back-pressure.");
    if (fail_count == 0) begin
      $display("** c_string_escape_decoder_unit: PASSED **");
    end else begin
      $display("** c_string_escape_decoder_unit: FAILED **");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/ced_pkg.sv
design/ced_front.sv
design/ced_queue.sv
design/ced_back.sv
design/c_string_escape_decoder_unit.sv
design/ced_checker.sv
tb/ced_decode_checker.sv
tb/tb_top.sv
